### hw/rtl/lca_pkg.sv
// Package: shared types and constants of the lowest common ancestor block.
`timescale 1ns / 1ps

package lca_pkg;

    localparam int NODE_W    = 7;
    localparam int NODES_DEF = 128;

    localparam logic CMD_LINK  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [NODE_W-1:0] child_node;
        logic [NODE_W-1:0] parent_node;
        logic [NODE_W-1:0] first_node;
        logic [NODE_W-1:0] second_node;
    } t_lca_in;

    typedef struct packed {
        logic              found;
        logic [NODE_W-1:0] ancestor_node;
    } t_lca_out;

endpackage

### hw/rtl/lca_in_if.sv
// Interface: request channel (link and query items) with valid/ready handshake.
`timescale 1ns / 1ps

interface lca_in_if
    import lca_pkg::*;
();
    logic    valid;
    logic    ready;
    t_lca_in payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/lca_out_if.sv
// Interface: result channel with valid/ready handshake.
`timescale 1ns / 1ps

interface lca_out_if
    import lca_pkg::*;
();
    logic     valid;
    logic     ready;
    t_lca_out payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/lowest_common_ancestor.sv
// Top level: lowest common ancestor by parent walk over a parent-table memory.
//
//  channel  dir  payload                                          result
//  i_in     in   cmd, child_node, parent_node, first/second_node  link: none
//  o_out    out  found, ancestor_node                              query: one
//
// A query walks up from the first node, marking each node, then walks up from the
// second node until it meets a mark; each walk makes at most NODES moves, with one
// parent-table read per move.
// Reset clears the link valid bits. The mark memory holds a query tag per node;
// a clearing pass over min(NODES, 128) entries runs after reset and after every
// 255th walked query, with the input held off meanwhile.
// A finished result waits in the output register; link items are still taken
// meanwhile, and a query that completes behind it holds until it is gone.
`timescale 1ns / 1ps

module lowest_common_ancestor
    import lca_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lca_in_if.sink     i_in,
    lca_out_if.source  o_out
);

    // only nodes below 2**NODE_W can ever be named
    localparam int TD = (NODES < (1 << NODE_W)) ? NODES : (1 << NODE_W);
    localparam int AW = $clog2(TD);
    localparam int SW = $clog2(NODES + 1);
    localparam int EW = 8;
    localparam logic [SW-1:0] STEP_CAP   = SW'(NODES);
    localparam logic [AW-1:0] LAST_IDX   = AW'(TD - 1);
    localparam logic [EW-1:0] EPOCH_LAST = '1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MARK,
        S_SEEK,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [NODE_W-1:0] r_ptab [TD];
    logic [NODE_W-1:0] r_ptab_q;
    logic [EW-1:0]     r_mtab [TD];
    logic [EW-1:0]     r_mtab_q;
    logic              r_mark_fwd;
    logic [EW-1:0]     r_epoch;
    logic [AW-1:0]     r_clr;
    logic [TD-1:0]     r_has;
    logic [NODE_W-1:0] r_node;
    logic [NODE_W-1:0] r_second;
    logic              r_from_mem;
    logic [SW-1:0]     r_steps;
    logic              r_res_found;
    logic              r_out_valid;
    t_lca_out          r_out;

    logic [NODE_W-1:0] cur;
    logic [AW-1:0]     cur_idx;
    logic [AW-1:0]     rd_idx;
    logic              in_xfer;
    logic              link_ok;
    logic              query_ok;
    logic              mem_we;
    logic              mem_re;
    logic              mark_we;
    logic              seek_start;
    logic              seek_marked;

    assign i_in.ready    = (r_state == S_IDLE);
    assign in_xfer       = i_in.valid && i_in.ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    assign link_ok  = (int'(i_in.payload.child_node) < NODES)
                   && (int'(i_in.payload.parent_node) < NODES);
    assign query_ok = (int'(i_in.payload.first_node) < NODES)
                   && (int'(i_in.payload.second_node) < NODES);

    // current walk node: straight from the memory output after a move of the mark walk
    assign cur     = r_from_mem ? r_ptab_q : r_node;
    assign cur_idx = cur[AW-1:0];

    assign mem_we     = in_xfer && (i_in.payload.cmd == CMD_LINK) && link_ok;
    assign mem_re     = (r_state == S_MARK) || (r_state == S_SEEK);
    assign mark_we    = (r_state == S_MARK);
    assign seek_start = (r_state == S_MARK) && !r_has[cur_idx];

    // seek reads one node ahead so its mark and parent arrive together
    assign rd_idx = (r_state == S_SEEK) ? r_ptab_q[AW-1:0]
                  : (seek_start ? r_second[AW-1:0] : cur_idx);

    // the last mark write can hit the second node read in the same cycle
    assign seek_marked = r_mark_fwd || (r_mtab_q == r_epoch);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_ptab[i_in.payload.child_node[AW-1:0]] <= i_in.payload.parent_node;
        end
        if (mem_re) begin
            r_ptab_q <= r_ptab[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            r_mtab[r_clr] <= '0;
        end else if (mark_we) begin
            r_mtab[cur_idx] <= r_epoch;
        end
        if (mem_re) begin
            r_mtab_q   <= r_mtab[rd_idx];
            r_mark_fwd <= mark_we && (cur_idx == rd_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_epoch     <= '0;
            r_has       <= '0;
            r_node      <= '0;
            r_second    <= '0;
            r_from_mem  <= 1'b0;
            r_steps     <= '0;
            r_res_found <= 1'b0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            if (r_out_valid && o_out.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_clr == LAST_IDX) begin
                        r_clr   <= '0;
                        r_epoch <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_clr <= r_clr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (in_xfer) begin
                        if (i_in.payload.cmd == CMD_LINK) begin
                            if (link_ok) begin
                                r_has[i_in.payload.child_node[AW-1:0]] <= 1'b1;
                            end
                        end else begin
                            if (query_ok) begin
                                r_epoch    <= r_epoch + 1'b1;
                                r_node     <= i_in.payload.first_node;
                                r_second   <= i_in.payload.second_node;
                                r_from_mem <= 1'b0;
                                r_steps    <= '0;
                                r_state    <= S_MARK;
                            end else begin
                                r_res_found <= 1'b0;
                                r_state     <= S_DONE;
                            end
                        end
                    end
                end
                S_MARK: begin
                    priority if (!r_has[cur_idx]) begin
                        r_node     <= r_second;
                        r_from_mem <= 1'b0;
                        r_steps    <= '0;
                        r_state    <= S_SEEK;
                    end else if (r_steps == STEP_CAP) begin
                        // cycle above the first node
                        r_res_found <= 1'b0;
                        r_from_mem  <= 1'b0;
                        r_state     <= S_DONE;
                    end else begin
                        r_from_mem <= 1'b1;
                        r_steps    <= r_steps + 1'b1;
                    end
                end
                S_SEEK: begin
                    priority if (seek_marked) begin
                        r_res_found <= 1'b1;
                        r_state     <= S_DONE;
                    end else if (!r_has[cur_idx] || (r_steps == STEP_CAP)) begin
                        r_res_found <= 1'b0;
                        r_state     <= S_DONE;
                    end else begin
                        r_node  <= r_ptab_q;
                        r_steps <= r_steps + 1'b1;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid         <= 1'b1;
                        r_out.found         <= r_res_found;
                        r_out.ancestor_node <= r_res_found ? r_node : '0;
                        r_state             <= (r_epoch == EPOCH_LAST) ? S_CLEAR : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### test/tb_lca_checker.sv
// Checker: scoreboard that predicts query results from observed transfers and compares.
`timescale 1ns / 1ps

module tb_lca_checker
    import lca_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    input  logic     i_req_ready,
    input  t_lca_in  i_req,
    input  logic     i_res_valid,
    input  logic     i_res_ready,
    input  t_lca_out i_res,
    output int       o_errors,
    output int       o_pending
);

    logic [NODE_W-1:0] parent_of [NODES];
    bit                has_parent [NODES];
    t_lca_out          expected_results [$];
    t_lca_out          want;

    // Mark the first node's chain, then climb from the second until a mark is hit.
    function automatic t_lca_out common_ancestor(int first, int second);
        bit       marked [NODES];
        int       node;
        int       steps;
        bit       ok;
        bit       done;
        t_lca_out res;
        res    = '0;
        marked = '{default: 1'b0};
        if (first >= NODES || second >= NODES) return res;

        node         = first;
        steps        = 0;
        ok           = 1'b1;
        marked[node] = 1'b1;
        while (ok && has_parent[node]) begin
            if (steps >= NODES) begin
                ok = 1'b0;  // cycle above the first node
            end else begin
                node = int'(parent_of[node]);
                if (node >= NODES) begin
                    ok = 1'b0;
                end else begin
                    steps++;
                    marked[node] = 1'b1;
                end
            end
        end
        if (!ok) return res;

        node  = second;
        steps = 0;
        done  = 1'b0;
        while (!done) begin
            if (marked[node]) begin
                res.found         = 1'b1;
                res.ancestor_node = node[NODE_W-1:0];
                done              = 1'b1;
            end else if (!has_parent[node] || steps >= NODES) begin
                done = 1'b1;
            end else begin
                node = int'(parent_of[node]);
                if (node >= NODES) done = 1'b1;
                steps++;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            has_parent = '{default: 1'b0};
            expected_results.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result: found %0b ancestor %0d",
                             $time, i_res.found, i_res.ancestor_node);
                    o_errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_res.found !== want.found) begin
                        $display("%0t: found mismatch: expected %0b actual %0b",
                                 $time, want.found, i_res.found);
                        o_errors++;
                    end
                    if (i_res.ancestor_node !== want.ancestor_node) begin
                        $display("%0t: ancestor mismatch: expected %0d actual %0d",
                                 $time, want.ancestor_node, i_res.ancestor_node);
                        o_errors++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                if (i_req.cmd == CMD_LINK) begin
                    if (int'(i_req.child_node) < NODES && int'(i_req.parent_node) < NODES) begin
                        parent_of[i_req.child_node]  = i_req.parent_node;
                        has_parent[i_req.child_node] = 1'b1;
                    end
                end else begin
                    expected_results.push_back(
                        common_ancestor(int'(i_req.first_node), int'(i_req.second_node)));
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

### test/tb_lowest_common_ancestor.sv
// Testbench top: drives link and query transfers into the block and reports the verdict.
`timescale 1ns / 1ps

module tb_lowest_common_ancestor;
    import lca_pkg::*;

    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int DRAIN_CYCLES = 2 * NODES_DEF + 8;
    localparam int RAND_ITEMS   = 1000;

    logic     i_clk     = 1'b0;
    logic     i_rst_n   = 1'b0;
    logic     req_valid = 1'b0;
    t_lca_in  req_data  = '0;
    logic     res_ready = 1'b0;
    bit       calm      = 1'b0;
    int       cycle_count = 0;
    int       sent        = 0;
    int       errors;
    int       pending;
    bit       used_child [NODES_DEF];

    lca_in_if  req_ch ();
    lca_out_if res_ch ();

    assign req_ch.valid   = req_valid;
    assign req_ch.payload = req_data;
    assign res_ch.ready   = res_ready;

    lowest_common_ancestor #(.NODES(NODES_DEF)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    tb_lca_checker #(.NODES(NODES_DEF)) checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_ch.valid),
        .i_req_ready (req_ch.ready),
        .i_req       (req_ch.payload),
        .i_res_valid (res_ch.valid),
        .i_res_ready (res_ch.ready),
        .i_res       (res_ch.payload),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        res_ready <= calm || ($urandom_range(0, 99) >= 15);
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send(input t_lca_in item);
        while (!calm && $urandom_range(0, 99) < 15) begin
            req_valid <= 1'b0;
            @(negedge i_clk);
        end
        req_valid <= 1'b1;
        req_data  <= item;
        do @(posedge i_clk); while (!req_ch.ready);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic link(input int child, input int parent);
        t_lca_in item;
        item.cmd         = CMD_LINK;
        item.child_node  = child[NODE_W-1:0];
        item.parent_node = parent[NODE_W-1:0];
        item.first_node  = NODE_W'($urandom);
        item.second_node = NODE_W'($urandom);
        used_child[child] = 1'b1;
        send(item);
    endtask

    task automatic query(input int first, input int second);
        t_lca_in item;
        item.cmd         = CMD_QUERY;
        item.child_node  = NODE_W'($urandom);
        item.parent_node = NODE_W'($urandom);
        item.first_node  = first[NODE_W-1:0];
        item.second_node = second[NODE_W-1:0];
        send(item);
    endtask

    task automatic shuffle(ref int q[$]);
        int j;
        int t;
        for (int i = q.size() - 1; i > 0; i--) begin
            j    = $urandom_range(0, i);
            t    = q[i];
            q[i] = q[j];
            q[j] = t;
        end
    endtask

    function automatic int pick_node(ref int members[$]);
        if ($urandom_range(0, 4) == 0) return $urandom_range(0, NODES_DEF - 1);
        return members[$urandom_range(0, members.size() - 1)];
    endfunction

    initial begin
        int reserved [$];
        int others   [$];
        int members  [$];
        int pool     [$];
        int root;
        int size;
        int parent;
        int first;
        int rand_start;
        bit deep;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        query(5, 5);        // lone root against itself
        query(0, 127);      // two separate roots
        link(1, 0);
        link(2, 1);
        link(3, 1);
        query(2, 3);
        query(3, 0);
        query(0, 2);        // first node is ancestor of the second
        link(127, 2);
        query(127, 3);
        query(127, 127);
        link(126, 127);
        query(126, 0);
        link(120, 121);     // two-node loop
        link(121, 120);
        query(120, 0);      // loop above the first node
        query(0, 120);      // loop above the second node
        link(121, 0);       // overwrite breaks the loop
        query(120, 2);
        link(125, 125);     // self loop
        query(125, 125);
        query(3, 125);

        // Nodes never linked stay true roots; trees hang from them.
        for (int n = 0; n < NODES_DEF; n++) if (!used_child[n]) pool.push_back(n);
        shuffle(pool);
        for (int n = 0; n < pool.size() && n < 6; n++) reserved.push_back(pool[n]);
        for (int n = 0; n < NODES_DEF; n++) begin
            if (!(n inside {reserved})) others.push_back(n);
        end

        rand_start = sent;
        while (sent - rand_start < RAND_ITEMS) begin
            calm = (sent - rand_start >= 400) && (sent - rand_start < 600);
            root = reserved[$urandom_range(0, reserved.size() - 1)];
            shuffle(others);
            deep = ($urandom_range(0, 9) == 0);
            size = deep ? $urandom_range(60, others.size()) : $urandom_range(1, 30);
            members.delete();
            members.push_back(root);
            for (int i = 0; i < size; i++) begin
                if (deep || $urandom_range(0, 1) == 0) parent = members[members.size() - 1];
                else parent = members[$urandom_range(0, members.size() - 1)];
                link(others[i], parent);
                members.push_back(others[i]);
            end
            repeat ($urandom_range(2, 8)) begin
                first = pick_node(members);
                if ($urandom_range(0, 9) == 0) query(first, first);
                else query(first, pick_node(members));
            end
            // noise: stray links may close loops until a later rebuild repairs them
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    link(others[$urandom_range(0, others.size() - 1)],
                         $urandom_range(0, NODES_DEF - 1));
                end
                repeat (2) query($urandom_range(0, NODES_DEF - 1), $urandom_range(0, NODES_DEF - 1));
            end
        end
        calm = 1'b0;
        req_valid <= 1'b0;

        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
